// ===== rtl/itp_pkg.sv =====
// itp_pkg: shared types, constants and the precedence function of the
// infix-to-postfix converter; no dependencies
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [2:0] PREC_PAREN = 3'd0;
  localparam logic [2:0] PREC_OPND  = 3'd1;
  localparam logic [2:0] PREC_ADD   = 3'd2;
  localparam logic [2:0] PREC_MUL   = 3'd3;
  localparam logic [2:0] PREC_POW   = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    K_OPERAND,
    K_LPAREN,
    K_RPAREN,
    K_OPERATOR
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RP,
    S_POP_OP,
    S_FLUSH,
    S_FINAL
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] prec;
    logic [7:0] sym;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic       run_last;
    logic       expr_done;
    logic [1:0] err;
  } res_t;

  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      CH_POW:                 p = PREC_POW;
      CH_MUL, CH_DIV, CH_MOD: p = PREC_MUL;
      CH_ADD, CH_SUB:         p = PREC_ADD;
      CH_LPAREN, CH_RPAREN:   p = PREC_PAREN;
      default:                p = PREC_OPND;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/itp_front.sv =====
// itp_front: takes input beats, classifies each symbol and queues the command
// depends on itp_pkg
module itp_front import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol,
  input  logic       end_of_expr,
  output logic       cmd_valid,
  output cmd_t       cmd_out,
  input  logic       cmd_pop
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              take;
  logic              give;

  always_comb begin
    cmd_in.sym  = symbol;
    cmd_in.last = end_of_expr;
    cmd_in.prec = prec_of(symbol);
    case (symbol)
      CH_LPAREN: cmd_in.kind = K_LPAREN;
      CH_RPAREN: cmd_in.kind = K_RPAREN;
      CH_POW, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB: cmd_in.kind = K_OPERATOR;
      default:   cmd_in.kind = K_OPERAND;
    endcase
  end

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd_out   = queue[rd_ptr];
  assign take      = push && !full;
  assign give      = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (take) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (give) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({take, give})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/itp_res_queue.sv =====
// itp_res_queue: short result queue in front of the output ports
// depends on itp_pkg
module itp_res_queue import itp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic room,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  res_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              take;
  logic              give;

  assign room    = (count != QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign res_out = queue[rd_ptr];
  assign take    = res_push && room;
  assign give    = pop && !empty;

  always_ff @(posedge clk) begin
    if (take) begin
      queue[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (give) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({take, give})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/itp_back.sv =====
// itp_back: operator stack and sequencer, one stack step and at most one
// result beat per cycle while the result queue has room; depends on itp_pkg
module itp_back import itp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd_in,
  output logic cmd_pop,
  input  logic room,
  output logic res_push,
  output res_t res_out
);

  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  state_t           state;
  state_t           state_next;
  cmd_t             cmd;
  logic             h_valid;
  logic             h_valid_next;
  logic [7:0]       h_sym;
  logic             h_has;
  logic [1:0]       h_err;

  cmd_t             cur;
  state_t           eff;
  state_t           goal;
  logic             fire;
  logic             done;
  logic             r_valid;
  logic [7:0]       r_sym;
  logic             r_has;
  logic [1:0]       r_err;
  logic             stk_pop;
  logic             stk_push;
  logic             stk_empty;
  logic             stk_full;
  logic [CNT_W-1:0] below_cnt;
  logic [7:0]       top;

  assign cur       = (state == S_IDLE) ? cmd_in : cmd;
  assign stk_empty = (count == '0);
  assign stk_full  = (count == CNT_W'(STACK_DEPTH));
  assign below_cnt = count - CNT_W'(2);
  assign fire      = room && ((state != S_IDLE) || cmd_valid);

  // one step of the sequencer
  always_comb begin
    r_valid  = 1'b0;
    r_sym    = '0;
    r_has    = 1'b0;
    r_err    = ERR_NONE;
    stk_pop  = 1'b0;
    stk_push = 1'b0;
    done     = 1'b0;
    goal     = state;
    eff      = state;
    if (state == S_IDLE) begin
      case (cur.kind)
        K_RPAREN:   eff = S_POP_RP;
        K_OPERATOR: eff = S_POP_OP;
        default:    eff = S_IDLE;
      endcase
    end
    case (eff)
      S_IDLE: begin
        if (cur.kind == K_OPERAND) begin
          r_valid = 1'b1;
          r_sym   = cur.sym;
          r_has   = 1'b1;
        end else if (stk_full) begin
          r_valid = 1'b1;
          r_err   = ERR_OVERFLOW;
        end else begin
          stk_push = 1'b1;
        end
        goal = cur.last ? S_FLUSH : S_IDLE;
        done = !cur.last;
      end
      S_POP_RP: begin
        if (!stk_empty && (top != CH_LPAREN)) begin
          r_valid = 1'b1;
          r_sym   = top;
          r_has   = 1'b1;
          stk_pop = 1'b1;
          goal    = S_POP_RP;
        end else begin
          if (stk_empty) begin
            r_valid = 1'b1;
            r_err   = ERR_UNMATCHED;
          end else begin
            stk_pop = 1'b1;
          end
          goal = cur.last ? S_FLUSH : S_IDLE;
          done = !cur.last;
        end
      end
      S_POP_OP: begin
        if (!stk_empty && (cur.prec <= prec_of(top))) begin
          r_valid = 1'b1;
          r_sym   = top;
          r_has   = 1'b1;
          stk_pop = 1'b1;
          goal    = S_POP_OP;
        end else begin
          if (stk_full) begin
            r_valid = 1'b1;
            r_err   = ERR_OVERFLOW;
          end else begin
            stk_push = 1'b1;
          end
          goal = cur.last ? S_FLUSH : S_IDLE;
          done = !cur.last;
        end
      end
      S_FLUSH: begin
        if (!stk_empty) begin
          r_valid = 1'b1;
          r_sym   = top;
          r_has   = 1'b1;
          stk_pop = 1'b1;
          goal    = S_FLUSH;
        end else begin
          goal = S_IDLE;
          done = 1'b1;
        end
      end
      default: begin
        goal = S_IDLE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    if (fire) begin
      if (state == S_FINAL) begin
        state_next = S_IDLE;
      end else if (done && r_valid && h_valid) begin
        state_next = S_FINAL;
      end else begin
        state_next = goal;
      end
    end
  end

  // outputs: the latest result is held back until it is known whether it ends the item
  always_comb begin
    cmd_pop            = fire && (state == S_IDLE);
    res_push           = 1'b0;
    res_out.sym        = h_sym;
    res_out.has        = h_has;
    res_out.err        = h_err;
    res_out.run_last   = 1'b0;
    res_out.expr_done  = 1'b0;
    h_valid_next       = h_valid;
    if (fire) begin
      if (state == S_FINAL) begin
        res_push          = 1'b1;
        res_out.run_last  = 1'b1;
        res_out.expr_done = cmd.last;
        h_valid_next      = 1'b0;
      end else if (r_valid && h_valid) begin
        res_push     = 1'b1;
        h_valid_next = 1'b1;
      end else if (done) begin
        res_out.run_last  = 1'b1;
        res_out.expr_done = cur.last;
        h_valid_next      = 1'b0;
        if (r_valid) begin
          res_push    = 1'b1;
          res_out.sym = r_sym;
          res_out.has = r_has;
          res_out.err = r_err;
        end else if (h_valid) begin
          res_push = 1'b1;
        end else if (cur.last) begin
          res_push    = 1'b1;
          res_out.sym = '0;
          res_out.has = 1'b0;
          res_out.err = ERR_NONE;
        end
      end else if (r_valid) begin
        h_valid_next = 1'b1;
      end
    end
  end

  // top of stack kept in a register, refilled from the entry below on a pop
  always_ff @(posedge clk) begin
    if (fire && stk_push) begin
      stack[count[IDX_W-1:0]] <= cur.sym;
      top                     <= cur.sym;
    end else if (fire && stk_pop) begin
      top <= stack[below_cnt[IDX_W-1:0]];
    end
    if (fire && (state == S_IDLE)) begin
      cmd <= cmd_in;
    end
    if (fire && r_valid) begin
      h_sym <= r_sym;
      h_has <= r_has;
      h_err <= r_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      h_valid <= 1'b0;
    end else begin
      state   <= state_next;
      h_valid <= h_valid_next;
      if (fire && stk_push) begin
        count <= count + 1'b1;
      end else if (fire && stk_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// infix_to_postfix_converter: shunting-yard top over itp_pkg, itp_front, itp_back, itp_res_queue
// flow: an operand not marked last passes itp_front, itp_back and itp_res_queue in turn; a beat
//   that does not end its item is held in itp_back so the item's final beat can be marked
// stepping: a ')' or operator pops stack entries in turn before it is placed; an error beat after
//   pops takes an extra final step, a last item also flushes the stack; steps wait for queue room
// reset: clears both queues, the stack count and the sequencer; stack contents are kept
module infix_to_postfix_converter import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol,
  input  logic       end_of_expr,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_symbol,
  output logic       has_symbol,
  output logic       run_last,
  output logic       expr_done,
  output logic [1:0] error_code
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic room;
  logic res_push;
  res_t res_in;
  res_t res_out;

  itp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .cmd_valid   (cmd_valid),
    .cmd_out     (cmd),
    .cmd_pop     (cmd_pop)
  );

  itp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_pop   (cmd_pop),
    .room      (room),
    .res_push  (res_push),
    .res_out   (res_in)
  );

  itp_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .room     (room),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign out_symbol = res_out.sym;
  assign has_symbol = res_out.has;
  assign run_last   = res_out.run_last;
  assign expr_done  = res_out.expr_done;
  assign error_code = res_out.err;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for infix_to_postfix_converter, driving character beats and
// checking postfix beats against a shunting-yard predictor kept in the bench
// depends on itp_pkg and infix_to_postfix_converter
module tb import itp_pkg::*;;

  localparam int unsigned LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 450;

  typedef struct {
    logic [7:0] sym;
    logic       last;
    bit         drain;
  } infix_char_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] symbol = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_symbol;
  logic       has_symbol;
  logic       run_last;
  logic       expr_done;
  logic [1:0] error_code;

  infix_to_postfix_converter u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .empty       (empty),
    .pop         (pop),
    .out_symbol  (out_symbol),
    .has_symbol  (has_symbol),
    .run_last    (run_last),
    .expr_done   (expr_done),
    .error_code  (error_code)
  );

  infix_char_t infix_q[$];
  res_t        postfix_q[$];
  res_t        item_beats[$];

  logic [7:0]  op_stack [STACK_DEPTH];
  int          op_depth = 0;

  int unsigned cyc = 0;
  int          sent_cnt = 0;
  int          taken_cnt = 0;
  int          queued_cnt = 0;
  int          beats_seen = 0;
  int          mismatches = 0;
  int          n_exprs = 0;
  int          n_overflow = 0;
  int          n_unmatched = 0;
  int          n_bare = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rank_of(input logic [7:0] c);
    case (c)
      CH_POW:                 return 4;
      CH_MUL, CH_DIV, CH_MOD: return 3;
      CH_ADD, CH_SUB:         return 2;
      CH_LPAREN, CH_RPAREN:   return 0;
      default:                return 1;
    endcase
  endfunction

  function automatic void emit_beat(input logic [7:0] s, input logic h, input logic [1:0] e);
    res_t b;
    b.sym = s;
    b.has = h;
    b.run_last = 1'b0;
    b.expr_done = 1'b0;
    b.err = e;
    item_beats.insert(item_beats.size(), b);
  endfunction

  function automatic void pop_op();
    op_depth--;
    emit_beat(op_stack[op_depth], 1'b1, ERR_NONE);
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (op_depth >= STACK_DEPTH) begin
      emit_beat(8'h00, 1'b0, ERR_OVERFLOW);
      n_overflow++;
    end else begin
      op_stack[op_depth] = c;
      op_depth++;
    end
  endfunction

  // expected postfix beats for one accepted character
  function automatic void predict_postfix(input logic [7:0] c, input logic last);
    int p;
    p = rank_of(c);
    item_beats.delete();
    if (p == 1) begin
      emit_beat(c, 1'b1, ERR_NONE);
    end else if (c == CH_LPAREN) begin
      push_op(c);
    end else if (c == CH_RPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CH_LPAREN) pop_op();
      if (op_depth > 0) begin
        op_depth--;
      end else begin
        emit_beat(8'h00, 1'b0, ERR_UNMATCHED);
        n_unmatched++;
      end
    end else begin
      while (op_depth > 0 && p <= rank_of(op_stack[op_depth-1])) pop_op();
      push_op(c);
    end
    if (last) begin
      while (op_depth > 0) pop_op();
      if (item_beats.size() == 0) begin
        emit_beat(8'h00, 1'b0, ERR_NONE);
        n_bare++;
      end
      item_beats[item_beats.size()-1].expr_done = 1'b1;
      n_exprs++;
    end
    if (item_beats.size() > 0) item_beats[item_beats.size()-1].run_last = 1'b1;
    foreach (item_beats[i]) postfix_q.insert(postfix_q.size(), item_beats[i]);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 5))
      0:       return CH_POW;
      1:       return CH_MUL;
      2:       return CH_DIV;
      3:       return CH_MOD;
      4:       return CH_ADD;
      default: return CH_SUB;
    endcase
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = 8'h61 + 8'($urandom_range(0, 25));
      2:    c = 8'h30 + 8'($urandom_range(0, 9));
      default: begin
        c = 8'($urandom_range(0, 255));
        while (rank_of(c) != 1) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  function automatic void queue_chars(input logic [7:0] s[$], input bit drain);
    infix_char_t it;
    foreach (s[i]) begin
      it.sym = s[i];
      it.last = (i == s.size() - 1);
      it.drain = drain && (i == 0);
      infix_q.insert(infix_q.size(), it);
      queued_cnt++;
    end
  endfunction

  function automatic void add_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.insert(s.size(), t[i]);
    queue_chars(s, 1'b0);
  endfunction

  // well-formed expression, now and then broken by one replaced or dropped character
  function automatic void gen_expr(input int len_target, input int max_nest, input bit drain);
    logic [7:0] s[$];
    int open;
    bit want_operand;
    int pos;
    open = 0;
    want_operand = 1'b1;
    while (1) begin
      if (want_operand) begin
        if (open < max_nest && $urandom_range(0, 99) < 25) begin
          s.insert(s.size(), CH_LPAREN);
          open++;
        end else begin
          s.insert(s.size(), pick_operand());
          want_operand = 1'b0;
        end
      end else if (open > 0 && $urandom_range(0, 99) < 30) begin
        s.insert(s.size(), CH_RPAREN);
        open--;
      end else if (s.size() >= len_target) begin
        break;
      end else begin
        s.insert(s.size(), pick_operator());
        want_operand = 1'b1;
      end
    end
    repeat (open) s.insert(s.size(), CH_RPAREN);
    pos = $urandom_range(0, s.size() - 1);
    case ($urandom_range(0, 9))
      0: s[pos] = 8'($urandom_range(0, 255));
      1: if (s.size() > 1) s.delete(pos);
      default: ;
    endcase
    queue_chars(s, drain);
  endfunction

  // nesting around the stack depth, at times deep enough to run the operator stack past its top
  function automatic void gen_deep(input bit drain);
    logic [7:0] s[$];
    int n;
    n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
    repeat (n) s.insert(s.size(), CH_LPAREN);
    repeat ($urandom_range(0, 3)) begin
      s.insert(s.size(), pick_operand());
      s.insert(s.size(), pick_operator());
    end
    s.insert(s.size(), pick_operand());
    repeat ($urandom_range(0, n + 2)) s.insert(s.size(), CH_RPAREN);
    queue_chars(s, drain);
  endfunction

  function automatic void gen_noise();
    logic [7:0] s[$];
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0, 1:    s.insert(s.size(), 8'($urandom_range(0, 255)));
        2:       s.insert(s.size(), pick_operator());
        default: s.insert(s.size(), $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      endcase
    end
    queue_chars(s, 1'b0);
  endfunction

  // stimulus and end of run
  initial begin
    logic [7:0] ext[$];
    int nexpr;
    int r;
    ext.insert(ext.size(), 8'h00);
    ext.insert(ext.size(), 8'hFF);
    queue_chars(ext, 1'b0);
    add_text("a+b-c*d/e%f^g");
    add_text("()");
    add_text(")");
    add_text("((a");
    add_text("a+b)");
    nexpr = 0;
    while (queued_cnt < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (nexpr == 1) gen_deep(1'b1);
      else if (r < 72) gen_expr($urandom_range(1, 15), $urandom_range(0, 4), nexpr % 20 == 0);
      else if (r < 80) gen_deep(nexpr % 20 == 0);
      else gen_noise();
      nexpr++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (infix_q.size() != 0 || sent_cnt != taken_cnt || push) @(negedge clk);
    while (postfix_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (postfix_q.size() != 0) $display("%0d expected beats never arrived", postfix_q.size());
    $display("covered %0d characters in %0d expressions, %0d postfix beats checked",
             taken_cnt, n_exprs, beats_seen);
    $display("overflows %0d, unmatched brackets %0d, bare end markers %0d, mismatches %0d",
             n_overflow, n_unmatched, n_bare, mismatches);
    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // character driver: bursts with random gaps, holds while a drain is pending
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    infix_char_t it;
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && sent_cnt != taken_cnt)) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (infix_q.size() == 0 || (infix_q[0].drain && postfix_q.size() != 0)) begin
        push <= 1'b0;
      end else begin
        it = infix_q.pop_front();
        push <= 1'b1;
        symbol <= it.sym;
        end_of_expr <= it.last;
        sent_cnt++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(15, 40);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // result receiver: stall pattern is picked anew whenever the low byte of the cycle counter is zero
  int stall_left = 0;
  int stall_mode = 0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (cyc[7:0] == 8'd0) stall_mode = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        case (stall_mode)
          1:       if ($urandom_range(0, 1)) stall_left = $urandom_range(1, 3);
          2:       if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(10, 40);
          3:       if ($urandom_range(0, 3) == 0) stall_left = 1;
          default: ;
        endcase
      end
    end
  end

  // monitor: predicts on every accepted character beat, checks every postfix beat
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (push && !full) begin
        predict_postfix(symbol, end_of_expr);
        taken_cnt++;
      end
      if (pop && !empty) begin
        got.sym = out_symbol;
        got.has = has_symbol;
        got.run_last = run_last;
        got.expr_done = expr_done;
        got.err = error_code;
        beats_seen++;
        if (postfix_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat sym=%h has=%b run_last=%b done=%b err=%0d",
                     $realtime, got.sym, got.has, got.run_last, got.expr_done, got.err);
          mismatches++;
        end else begin
          want = postfix_q.pop_front();
          if (got.sym !== want.sym || got.has !== want.has || got.run_last !== want.run_last ||
              got.expr_done !== want.expr_done || got.err !== want.err) begin
            if (mismatches < 10)
              $display({"%0t: mismatch exp sym=%h has=%b rl=%b done=%b err=%0d, ",
                        "got sym=%h has=%b rl=%b done=%b err=%0d"},
                       $realtime, want.sym, want.has, want.run_last, want.expr_done, want.err,
                       got.sym, got.has, got.run_last, got.expr_done, got.err);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== files.f =====
rtl/itp_pkg.sv
rtl/itp_front.sv
rtl/itp_res_queue.sv
rtl/itp_back.sv
rtl/infix_to_postfix_converter.sv
tb/sv/tb.sv
